// ----- design/hic_pkg.sv -----
// Shared types and constants for the homography inlier classifier.
`timescale 1ns / 1ps
package hic_pkg;

  localparam int CoordW   = 24;
  localparam int AccW     = 58;   // x', y', w' accumulators
  localparam int QuotW    = 40;   // quotient bits below the saturation limit
  localparam int ErrW     = 40;
  localparam int PairW    = 16;
  localparam int InlW     = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [ErrW-1:0]  ERR_MAX  = {ErrW{1'b1}};
  localparam logic [PairW-1:0] PAIR_CAP = 16'hFFFF;
  localparam logic [InlW-1:0]  INL_CAP  = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_AB    = 3'd0,
    REG_ROW0C_ROW1A = 3'd1,
    REG_ROW1_BC    = 3'd2,
    REG_ROW2_AB    = 3'd3,
    REG_ROW2_C     = 3'd4,
    REG_TOL_SQ     = 3'd5
  } reg_idx_t;

  // Multiplier operand select
  typedef enum logic [2:0] {
    SEL_H00_X = 3'd0,
    SEL_H01_Y = 3'd1,
    SEL_H10_X = 3'd2,
    SEL_H11_Y = 3'd3,
    SEL_H20_X = 3'd4,
    SEL_H21_Y = 3'd5,
    SEL_DX_SQ = 3'd6,
    SEL_DY_SQ = 3'd7
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MDRAIN,
    ST_DSTART,
    ST_DWAIT,
    ST_DIFF,
    ST_SQ,
    ST_MDRAIN_E,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t sel;
    logic     div_start;
    logic     diff_en;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ----- design/hic_if.sv -----
// Valid/ready channel interfaces for correspondence items and results.
`timescale 1ns / 1ps
interface hic_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [hic_pkg::CoordW-1:0] src_x;
  logic signed [hic_pkg::CoordW-1:0] src_y;
  logic signed [hic_pkg::CoordW-1:0] dst_x;
  logic signed [hic_pkg::CoordW-1:0] dst_y;
  logic                          last_pair;
  modport source (output valid, src_x, src_y, dst_x, dst_y, last_pair, input ready);
  modport sink (input valid, src_x, src_y, dst_x, dst_y, last_pair, output ready);
endinterface

interface hic_out_if;
  logic                         valid;
  logic                         ready;
  logic [hic_pkg::PairW-1:0]    pair_index;
  logic                         is_inlier;
  logic                         degenerate;
  logic [hic_pkg::ErrW-1:0]     error_sq;
  logic [hic_pkg::InlW-1:0]     inliers_so_far;
  logic                         set_done;
  modport source (output valid, pair_index, is_inlier, degenerate, error_sq,
                  inliers_so_far, set_done, input ready);
  modport sink (input valid, pair_index, is_inlier, degenerate, error_sq,
                inliers_so_far, set_done, output ready);
endinterface

// ----- design/hic_div.sv -----
// Restoring divider: min(num * 2^8 / den, 2^40), one quotient bit per cycle.
`timescale 1ns / 1ps
module hic_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hic_pkg::AccW-1:0]    num,
  input  logic [hic_pkg::AccW-1:0]    den,
  output logic                        busy,
  output logic [hic_pkg::QuotW:0]     quo
);
  logic                        busy_r;
  logic [5:0]                  cnt_r;
  logic [hic_pkg::AccW-1:0]    rem_r, rem_nxt;
  logic [hic_pkg::AccW-1:0]    den_r;
  logic [hic_pkg::QuotW-1:0]   sh_r;
  logic [hic_pkg::QuotW-1:0]   q_r;
  logic                        sat_r;
  logic [hic_pkg::AccW:0]      trial;
  logic [hic_pkg::AccW:0]      diff;
  logic                        ge;

  always_comb begin
    trial   = {rem_r, sh_r[hic_pkg::QuotW-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[hic_pkg::AccW-1:0] : trial[hic_pkg::AccW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == 6'(hic_pkg::QuotW - 1)) busy_r <= 1'b0;
      cnt_r <= cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient of 2^40 or more saturates; otherwise the first remainder is below den
      sat_r <= ({32'b0, num} >= {den, 32'b0});
      rem_r <= {32'b0, num[hic_pkg::AccW-1:32]};
      sh_r  <= {num[31:0], 8'b0};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[hic_pkg::QuotW-2:0], 1'b0};
      q_r   <= {q_r[hic_pkg::QuotW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = sat_r ? {1'b1, {hic_pkg::QuotW{1'b0}}} : {1'b0, q_r};
endmodule

// ----- design/hic_ctrl.sv -----
// Controller state machine sequencing the transform, divides and error step.
`timescale 1ns / 1ps
module hic_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hic_pkg::status_t status,
  output hic_pkg::cmd_t    cmd
);
  hic_pkg::state_t state_r, state_nxt;
  logic [2:0]      k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hic_pkg::ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = hic_pkg::mul_sel_t'(k_r);
    unique case (state_r)
      hic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          k_nxt     = 3'(hic_pkg::SEL_H00_X);
          state_nxt = hic_pkg::ST_MUL;
        end
      end
      hic_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        k_nxt      = k_r + 3'd1;
        if (k_r == 3'(hic_pkg::SEL_H21_Y)) state_nxt = hic_pkg::ST_MDRAIN;
      end
      hic_pkg::ST_MDRAIN: state_nxt = hic_pkg::ST_DSTART;
      hic_pkg::ST_DSTART: begin
        if (status.degen) begin
          state_nxt = hic_pkg::ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = hic_pkg::ST_DWAIT;
        end
      end
      hic_pkg::ST_DWAIT: if (!status.div_busy) state_nxt = hic_pkg::ST_DIFF;
      hic_pkg::ST_DIFF: begin
        cmd.diff_en = 1'b1;
        k_nxt       = 3'(hic_pkg::SEL_DX_SQ);
        state_nxt   = hic_pkg::ST_SQ;
      end
      hic_pkg::ST_SQ: begin
        cmd.mul_en = 1'b1;
        k_nxt      = k_r + 3'd1;
        // let the last square settle into the sum before emitting
        if (k_r == 3'(hic_pkg::SEL_DY_SQ)) state_nxt = hic_pkg::ST_MDRAIN_E;
      end
      hic_pkg::ST_MDRAIN_E: state_nxt = hic_pkg::ST_EMIT;
      hic_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = hic_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hic_pkg::ST_IDLE;
    endcase
  end
endmodule

// ----- design/hic_datapath.sv -----
// Datapath: coefficient registers, shared multiplier, two dividers, counters, result register.
`timescale 1ns / 1ps
module hic_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hic_pkg::cmd_t                     cmd,
  output hic_pkg::status_t                  status,
  input  logic                              cfg_we,
  input  logic [hic_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [hic_pkg::CfgDataW-1:0]      cfg_wdata,
  input  logic signed [hic_pkg::CoordW-1:0] src_x,
  input  logic signed [hic_pkg::CoordW-1:0] src_y,
  input  logic signed [hic_pkg::CoordW-1:0] dst_x,
  input  logic signed [hic_pkg::CoordW-1:0] dst_y,
  input  logic                              last_pair,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hic_pkg::PairW-1:0]         pair_index,
  output logic                              is_inlier,
  output logic                              degenerate,
  output logic [hic_pkg::ErrW-1:0]          error_sq,
  output logic [hic_pkg::InlW-1:0]          inliers_so_far,
  output logic                              set_done
);
  localparam int AW = hic_pkg::AccW;

  logic [63:0] row0_ab_r, row0c_row1a_r, row1_bc_r, row2_ab_r;
  logic [31:0] row2_c_r;
  logic [hic_pkg::ErrW-1:0] tol_r;

  logic signed [hic_pkg::CoordW-1:0] sx_r, sy_r, dx_r, dy_r;
  logic                              last_r;

  logic signed [AW-1:0] xp_r, yp_r, wp_r;
  logic [63:0]          esum_r;
  logic signed [32:0]   opa, opb;
  logic signed [65:0]   prod_r;
  logic signed [65:0]   prod_sh2, prod_sh8;
  hic_pkg::mul_sel_t    psel_r;
  logic                 pv_r;

  logic [AW-1:0]        nx, ny, nw;
  logic                 busy_x, busy_y;
  logic [hic_pkg::QuotW:0] qx, qy;
  logic signed [42:0]   ux, uy, ex, ey;
  logic [42:0]          mx, my;
  logic [30:0]          mdx_r, mdy_r;
  logic                 esat_r;
  logic                 degen;

  logic [hic_pkg::ErrW-1:0]  err;
  logic                      inl;
  logic [hic_pkg::PairW-1:0] pair_r;
  logic [hic_pkg::InlW-1:0]  inl_r, inl_nxt;

  logic                      ov_r;
  logic [hic_pkg::PairW-1:0] o_pair_r;
  logic                      o_inl_r, o_deg_r, o_last_r;
  logic [hic_pkg::ErrW-1:0]  o_err_r;
  logic [hic_pkg::InlW-1:0]  o_cnt_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_ab_r     <= 64'h0100_0000_0000_0000;
      row0c_row1a_r <= '0;
      row1_bc_r     <= 64'h0100_0000_0000_0000;
      row2_ab_r     <= '0;
      row2_c_r      <= 32'h0100_0000;
      tol_r         <= 40'd589824;
    end else if (cfg_we) begin
      priority case (cfg_index)
        hic_pkg::REG_ROW0_AB:     row0_ab_r     <= cfg_wdata;
        hic_pkg::REG_ROW0C_ROW1A: row0c_row1a_r <= cfg_wdata;
        hic_pkg::REG_ROW1_BC:     row1_bc_r     <= cfg_wdata;
        hic_pkg::REG_ROW2_AB:     row2_ab_r     <= cfg_wdata;
        hic_pkg::REG_ROW2_C:      row2_c_r      <= cfg_wdata[31:0];
        hic_pkg::REG_TOL_SQ:      tol_r         <= cfg_wdata[hic_pkg::ErrW-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.sel)
      hic_pkg::SEL_H00_X: begin opa = 33'(signed'(row0_ab_r[63:32]));     opb = 33'(sx_r); end
      hic_pkg::SEL_H01_Y: begin opa = 33'(signed'(row0_ab_r[31:0]));      opb = 33'(sy_r); end
      hic_pkg::SEL_H10_X: begin opa = 33'(signed'(row0c_row1a_r[31:0]));  opb = 33'(sx_r); end
      hic_pkg::SEL_H11_Y: begin opa = 33'(signed'(row1_bc_r[63:32]));     opb = 33'(sy_r); end
      hic_pkg::SEL_H20_X: begin opa = 33'(signed'(row2_ab_r[63:32]));     opb = 33'(sx_r); end
      hic_pkg::SEL_H21_Y: begin opa = 33'(signed'(row2_ab_r[31:0]));      opb = 33'(sy_r); end
      hic_pkg::SEL_DX_SQ: begin opa = {2'b0, mdx_r}; opb = {2'b0, mdx_r}; end
      hic_pkg::SEL_DY_SQ: begin opa = {2'b0, mdy_r}; opb = {2'b0, mdy_r}; end
      default:            begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_sh2 = prod_r >>> 2;
  assign prod_sh8 = prod_r >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    psel_r <= cmd.sel;
    if (cmd.load) begin
      sx_r   <= src_x;
      sy_r   <= src_y;
      dx_r   <= dst_x;
      dy_r   <= dst_y;
      last_r <= last_pair;
      xp_r   <= {{12{row0c_row1a_r[63]}}, row0c_row1a_r[63:32], 14'b0};
      yp_r   <= {{12{row1_bc_r[31]}}, row1_bc_r[31:0], 14'b0};
      wp_r   <= {{20{row2_c_r[31]}}, row2_c_r, 6'b0};
      esum_r <= '0;
    end else if (pv_r) begin
      unique case (psel_r)
        hic_pkg::SEL_H00_X, hic_pkg::SEL_H01_Y: xp_r <= xp_r + prod_sh2[AW-1:0];
        hic_pkg::SEL_H10_X, hic_pkg::SEL_H11_Y: yp_r <= yp_r + prod_sh2[AW-1:0];
        hic_pkg::SEL_H20_X, hic_pkg::SEL_H21_Y: wp_r <= wp_r + prod_sh8[AW-1:0];
        hic_pkg::SEL_DX_SQ, hic_pkg::SEL_DY_SQ: esum_r <= esum_r + prod_r[63:0];
        default: ;
      endcase
    end
  end

  // perspective divide, both quotients at once
  assign nx = xp_r[AW-1] ? AW'(-xp_r) : AW'(xp_r);
  assign ny = yp_r[AW-1] ? AW'(-yp_r) : AW'(yp_r);
  assign nw = wp_r[AW-1] ? AW'(-wp_r) : AW'(wp_r);
  assign degen = (wp_r == '0);

  hic_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(nx), .den(nw), .busy(busy_x), .quo(qx)
  );
  hic_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(ny), .den(nw), .busy(busy_y), .quo(qy)
  );

  always_comb begin
    ux = (xp_r[AW-1] ^ wp_r[AW-1]) ? -43'(qx) : 43'(qx);
    uy = (yp_r[AW-1] ^ wp_r[AW-1]) ? -43'(qy) : 43'(qy);
    ex = ux - 43'(dx_r);
    ey = uy - 43'(dy_r);
    mx = ex[42] ? 43'(-ex) : 43'(ex);
    my = ey[42] ? 43'(-ey) : 43'(ey);
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      mdx_r  <= mx[30:0];
      mdy_r  <= my[30:0];
      esat_r <= (mx[42:31] != '0) || (my[42:31] != '0);
    end
  end

  always_comb begin
    if (degen || esat_r || (esum_r[63:hic_pkg::ErrW] != '0)) err = hic_pkg::ERR_MAX;
    else                                                     err = esum_r[hic_pkg::ErrW-1:0];
    inl     = !degen && (err <= tol_r);
    inl_nxt = (inl && (inl_r < hic_pkg::INL_CAP)) ? inl_r + 1'b1 : inl_r;
  end

  // counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pair_r <= '0;
      inl_r  <= '0;
    end else begin
      if (cmd.emit)      ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cmd.emit) begin
        if (last_r) begin
          pair_r <= '0;
          inl_r  <= '0;
        end else begin
          inl_r <= inl_nxt;
          if (pair_r < hic_pkg::PAIR_CAP) pair_r <= pair_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_pair_r <= pair_r;
      o_inl_r  <= inl;
      o_deg_r  <= degen;
      o_err_r  <= err;
      o_cnt_r  <= inl_nxt;
      o_last_r <= last_r;
    end
  end

  assign status.degen    = degen;
  assign status.div_busy = busy_x || busy_y;
  assign status.out_free = !ov_r || out_ready;

  assign out_valid      = ov_r;
  assign pair_index     = o_pair_r;
  assign is_inlier      = o_inl_r;
  assign degenerate     = o_deg_r;
  assign error_sq       = o_err_r;
  assign inliers_so_far = o_cnt_r;
  assign set_done       = o_last_r;
endmodule

// ----- design/homography_inlier_classifier.sv -----
// Top level of the homography inlier classifier.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one point correspondence per transaction (source and
//   destination point, Q16.8, plus last_pair). out_ch returns one result per
//   item: pair index, inlier and degenerate flags, saturated squared error
//   (Q24.16), running inlier count and set_done.
//   cfg_we/cfg_index/cfg_wdata write the homography and the squared
//   tolerance; write only while the block is idle.
// Timing:
//   One item at a time. A regular item runs from accept to result valid as:
//   6 multiplies on one shared multiplier and a drain step, a divider start,
//   the two parallel bit-per-cycle dividers, a difference step, 2 squaring
//   multiplies, a drain step and the emit.
//   A degenerate item (w' of zero) skips the divide, difference and squares.
//   The next item is accepted once the result is in the output register.
// Reset:
//   rst_n clears the counters, the output valid and loads the identity
//   homography with a squared tolerance of 9.0.
// Stall:
//   A held result keeps the next finished item waiting in the datapath
//   until the output register frees up; no new item is accepted meanwhile.
module homography_inlier_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  hic_in_if.sink                             in_ch,
  hic_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [hic_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [hic_pkg::CfgDataW-1:0]       cfg_wdata
);
  hic_pkg::cmd_t    cmd;
  hic_pkg::status_t status;

  hic_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .status(status), .cmd(cmd)
  );

  hic_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .src_x(in_ch.src_x), .src_y(in_ch.src_y),
    .dst_x(in_ch.dst_x), .dst_y(in_ch.dst_y), .last_pair(in_ch.last_pair),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .pair_index(out_ch.pair_index), .is_inlier(out_ch.is_inlier),
    .degenerate(out_ch.degenerate), .error_sq(out_ch.error_sq),
    .inliers_so_far(out_ch.inliers_so_far), .set_done(out_ch.set_done)
  );
endmodule

// ----- design/hic_checker.sv -----
// Port-level checker for the homography inlier classifier, bound to the top level.
`timescale 1ns / 1ps
module hic_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       is_inlier,
  input logic                       degenerate,
  input logic [hic_pkg::ErrW-1:0]   error_sq,
  input logic [hic_pkg::InlW-1:0]   inliers_so_far
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(error_sq))
    else $error("error_sq changed while stalled");

  a_degen_not_inlier: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> !is_inlier && error_sq == hic_pkg::ERR_MAX)
    else $error("degenerate result flagged inlier or unsaturated");

  a_inlier_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_inlier |-> inliers_so_far != '0)
    else $error("inlier with zero running count");
endmodule

bind homography_inlier_classifier hic_checker u_hic_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .is_inlier(out_ch.is_inlier), .degenerate(out_ch.degenerate),
  .error_sq(out_ch.error_sq), .inliers_so_far(out_ch.inliers_so_far)
);

// ----- test/homography_inlier_classifier_tb.sv -----
// Self-checking bench: directed table and random correspondences against a homography predictor.
`timescale 1ns / 1ps
module homography_inlier_classifier_tb;

  localparam int IdleLimit = 4000;
  localparam int CW = hic_pkg::CoordW;
  localparam logic [hic_pkg::CfgIdxW-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [hic_pkg::CfgIdxW-1:0] IDX_SPARE_B = 3'd7;
  localparam logic [127:0] QUOT_SAT = 128'h1 << 40;

  typedef struct packed {
    logic [hic_pkg::PairW-1:0] idx;
    logic                      inl;
    logic                      deg;
    logic [hic_pkg::ErrW-1:0]  err;
    logic [hic_pkg::InlW-1:0]  cnt;
    logic                      done;
  } verdict_t;

  typedef struct {
    int                   phase;
    logic signed [CW-1:0] sx, sy, dx, dy;
    bit                   last;
    bit                   typed;
    verdict_t             res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [hic_pkg::CfgIdxW-1:0] cfg_index;
  logic [hic_pkg::CfgDataW-1:0] cfg_wdata;

  hic_in_if  in_ch ();
  hic_out_if out_ch ();

  homography_inlier_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the homography, tolerance and set counters
  logic [63:0] h_row0_ab, h_row0c_row1a, h_row1_bc, h_row2_ab;
  logic [31:0] h_row2_c;
  logic [hic_pkg::ErrW-1:0] tol_sq;
  logic [hic_pkg::PairW-1:0] pair_cnt;
  logic [hic_pkg::InlW-1:0] inl_cnt;

  verdict_t verdict_q[$];
  int errors = 0;
  int burst_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int idle_cycles = 0;
  dir_row_t dir_tab [14];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint div_q8(input longint num, input longint den);
    logic [127:0] n, d, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << 8) / d;
    if (q > QUOT_SAT) q = QUOT_SAT;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void project(input logic signed [CW-1:0] sx, sy,
                                  output longint u, v, output bit degen);
    longint x, y, h00, h01, h02, h10, h11, h12, h20, h21, h22, xp, yp, wp;
    x = sx;
    y = sy;
    h00 = $signed(h_row0_ab[63:32]);
    h01 = $signed(h_row0_ab[31:0]);
    h02 = $signed(h_row0c_row1a[63:32]);
    h10 = $signed(h_row0c_row1a[31:0]);
    h11 = $signed(h_row1_bc[63:32]);
    h12 = $signed(h_row1_bc[31:0]);
    h20 = $signed(h_row2_ab[63:32]);
    h21 = $signed(h_row2_ab[31:0]);
    h22 = $signed(h_row2_c);
    xp = ((h00 * x) >>> 2) + ((h01 * y) >>> 2) + h02 * 16384;
    yp = ((h10 * x) >>> 2) + ((h11 * y) >>> 2) + h12 * 16384;
    wp = ((h20 * x) >>> 8) + ((h21 * y) >>> 8) + h22 * 64;
    degen = (wp == 0);
    u = 0;
    v = 0;
    if (!degen) begin
      u = div_q8(xp, wp);
      v = div_q8(yp, wp);
    end
  endfunction

  function automatic bit sq_term(input longint a, b, output logic [63:0] sq);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    sq = 0;
    if (d >= (64'sd1 <<< 31)) return 0;
    sq = d * d;
    return 1;
  endfunction

  function automatic verdict_t classify_pair(input logic signed [CW-1:0] sx, sy, dx, dy,
                                             input bit last);
    verdict_t r;
    longint u, v;
    bit degen;
    logic [63:0] ex, ey, s;
    project(sx, sy, u, v, degen);
    r.err = hic_pkg::ERR_MAX;
    r.inl = 0;
    if (!degen) begin
      if (sq_term(u, dx, ex) && sq_term(v, dy, ey)) begin
        s = ex + ey;
        r.err = (s > {24'd0, hic_pkg::ERR_MAX}) ? hic_pkg::ERR_MAX : s[hic_pkg::ErrW-1:0];
      end
      r.inl = (r.err <= tol_sq);
    end
    if (r.inl && inl_cnt < hic_pkg::INL_CAP) inl_cnt++;
    r.idx = pair_cnt;
    r.deg = degen;
    r.cnt = inl_cnt;
    r.done = last;
    if (last) begin
      pair_cnt = 0;
      inl_cnt = 0;
    end else if (pair_cnt < hic_pkg::PAIR_CAP) begin
      pair_cnt++;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [hic_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      hic_pkg::REG_ROW0_AB:     h_row0_ab = val;
      hic_pkg::REG_ROW0C_ROW1A: h_row0c_row1a = val;
      hic_pkg::REG_ROW1_BC:     h_row1_bc = val;
      hic_pkg::REG_ROW2_AB:     h_row2_ab = val;
      hic_pkg::REG_ROW2_C:      h_row2_c = val[31:0];
      hic_pkg::REG_TOL_SQ:      tol_sq = val[hic_pkg::ErrW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one item, hold it until the transaction, then record its verdict
  task automatic send_item(input logic signed [CW-1:0] sx, sy, dx, dy, input bit last,
                           input bit typed, input verdict_t want);
    verdict_t r;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.src_x <= sx;
    in_ch.src_y <= sy;
    in_ch.dst_x <= dx;
    in_ch.dst_y <= dy;
    in_ch.last_pair <= last;
    do @(posedge clk); while (!in_ch.ready);
    r = classify_pair(sx, sy, dx, dy, last);
    verdict_q = {verdict_q, (typed ? want : r)};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_dir_phase(input int p);
    case (p)
      1: write_reg(hic_pkg::REG_TOL_SQ, {24'd0, hic_pkg::ERR_MAX});
      2: begin
        write_reg(hic_pkg::REG_ROW2_AB, 64'd0);
        write_reg(hic_pkg::REG_ROW2_C, 64'd0);
        write_reg(IDX_SPARE_A, '1);
        write_reg(IDX_SPARE_B, 64'h0123_4567_89AB_CDEF);
      end
      3: begin
        write_reg(hic_pkg::REG_ROW2_AB, {32'd256, 32'd256});
        write_reg(hic_pkg::REG_TOL_SQ, 64'd589824);
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] near(input logic [31:0] base, input int spread);
    return base + $urandom_range(0, 2 * spread) - spread;
  endfunction

  task automatic set_rand_phase(input int p);
    logic [31:0] a, b, c, d, e, f, g, h, k;
    logic [63:0] t;
    a = near(32'h0100_0000, 1 << 19);
    b = near(0, 1 << 19);
    c = near(0, 1 << 23);
    d = near(0, 1 << 19);
    e = near(32'h0100_0000, 1 << 19);
    f = near(0, 1 << 23);
    g = near(0, 1 << 16);
    h = near(0, 1 << 16);
    k = near(32'h0100_0000, 1 << 20);
    t = {$urandom, $urandom} & 64'h3F_FFFF;
    case (p)
      0: begin
        {a, b, c, d, e, f, g, h, k} = '1;
        t = {24'd0, hic_pkg::ERR_MAX};
      end
      1: begin
        {a, c, e, g} = {4{32'h8000_0000}};
        {b, d, f, h} = {4{32'h7FFF_FFFF}};
        k = 32'h8000_0000;
        t = 0;
      end
      2: begin
        a = 32'h0100_0000;
        b = 0;
        g = 256;
        h = 256;
        k = 0;
      end
      5: begin
        {a, b, c, d, e, f, g, h, k} = {$urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom};
        t = {$urandom, $urandom};
      end
      default: ;
    endcase
    write_reg(hic_pkg::REG_ROW0_AB, {a, b});
    write_reg(hic_pkg::REG_ROW0C_ROW1A, {c, d});
    write_reg(hic_pkg::REG_ROW1_BC, {e, f});
    write_reg(hic_pkg::REG_ROW2_AB, {g, h});
    write_reg(hic_pkg::REG_ROW2_C, {$urandom, k});
    write_reg(hic_pkg::REG_TOL_SQ, t);
  endtask

  task automatic rand_item();
    logic signed [CW-1:0] sx, sy, dx, dy;
    longint u, v;
    bit degen;
    int pick, spread;
    pick = $urandom_range(0, 99);
    sx = ($urandom_range(0, 1) == 0) ? CW'($urandom) : CW'($urandom_range(0, 8191) - 4096);
    sy = ($urandom_range(0, 1) == 0) ? CW'($urandom) : CW'($urandom_range(0, 8191) - 4096);
    dx = CW'($urandom);
    dy = CW'($urandom);
    if (pick < 12) begin
      sy = -sx;
    end else if (pick < 70) begin
      project(sx, sy, u, v, degen);
      spread = ($urandom_range(0, 1) == 0) ? 8 : 1024;
      if (!degen && u > -8380000 && u < 8380000 && v > -8380000 && v < 8380000) begin
        dx = CW'(u + $urandom_range(0, 2 * spread) - spread);
        dy = CW'(v + $urandom_range(0, 2 * spread) - spread);
      end
    end
    send_item(sx, sy, dx, dy, $urandom_range(0, 19) == 0, 1'b0, '0);
  endtask

  // Receiver: stall pattern of its own, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        report("unexpected result", out_ch.pair_index, 0);
      end else begin
        e = verdict_q.pop_front();
        if (out_ch.pair_index !== e.idx) report("pair_index", out_ch.pair_index, e.idx);
        if (out_ch.is_inlier !== e.inl) report("is_inlier", out_ch.is_inlier, e.inl);
        if (out_ch.degenerate !== e.deg) report("degenerate", out_ch.degenerate, e.deg);
        if (out_ch.error_sq !== e.err) report("error_sq", out_ch.error_sq, e.err);
        if (out_ch.inliers_so_far !== e.cnt) report("inliers_so_far", out_ch.inliers_so_far, e.cnt);
        if (out_ch.set_done !== e.done) report("set_done", out_ch.set_done, e.done);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("homography_inlier_classifier_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int cur;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.src_x = '0;
    in_ch.src_y = '0;
    in_ch.dst_x = '0;
    in_ch.dst_y = '0;
    in_ch.last_pair = 1'b0;
    out_ch.ready = 1'b0;
    h_row0_ab = 64'h0100_0000_0000_0000;
    h_row0c_row1a = 0;
    h_row1_bc = 64'h0100_0000_0000_0000;
    h_row2_ab = 0;
    h_row2_c = 32'h0100_0000;
    tol_sq = 40'd589824;
    pair_cnt = 0;
    inl_cnt = 0;

    // Reset config is the identity, so u equals src and the error reads off directly
    dir_tab = '{
      '{0, 0, 0, 0, 0, 0, 1, '{0, 1, 0, 0, 1, 0}},
      '{0, 0, 0, 768, 0, 0, 1, '{1, 1, 0, 589824, 2, 0}},
      '{0, 0, 0, 769, 0, 0, 1, '{2, 0, 0, 591361, 2, 0}},
      '{0, 8388607, -8388608, -8388608, 8388607, 0, 1, '{3, 0, 0, hic_pkg::ERR_MAX, 2, 0}},
      '{0, 100, -100, 100, -100, 1, 1, '{4, 1, 0, 0, 3, 1}},
      '{0, -8388608, -8388608, -8388608, -8388608, 1, 1, '{0, 1, 0, 0, 1, 1}},
      '{0, 1234, -5678, 1300, -5600, 0, 0, '0},
      '{1, 8388607, 0, -8388608, 0, 0, 1, '{1, 1, 0, hic_pkg::ERR_MAX, 2, 0}},
      '{1, -3, 7, 77, -9, 1, 0, '0},
      '{2, 0, 0, 0, 0, 0, 1, '{0, 0, 1, hic_pkg::ERR_MAX, 0, 0}},
      '{2, 8388607, -8388608, 0, 0, 1, 1, '{1, 0, 1, hic_pkg::ERR_MAX, 0, 1}},
      '{3, 5, -5, 0, 0, 0, 1, '{0, 0, 1, hic_pkg::ERR_MAX, 0, 0}},
      '{3, 300, -100, 1200, -400, 0, 0, '0},
      '{3, -8388608, 8388607, 4000, -4000, 1, 0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].phase != cur) begin
        drain();
        cur = dir_tab[i].phase;
        set_dir_phase(cur);
      end
      send_item(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].dx, dir_tab[i].dy, dir_tab[i].last,
                dir_tab[i].typed, dir_tab[i].res);
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      set_rand_phase(p);
      if (p == 3) hold_req = 1;
      repeat (100) rand_item();
    end

    drain();
    if (verdict_q.size() != 0) report("results missing", verdict_q.size(), 0);
    if (errors == 0) begin
      $display("homography_inlier_classifier_tb OK");
    end else begin
      $display("homography_inlier_classifier_tb NOT OK");
    end
    $finish;
  end

endmodule
